// ----- design/abst_pkg.sv -----
// Shared types and codes for the array-backed binary search tree unit.
// Used by abst_ctrl, abst_dp and the top level; depends on nothing.
package abst_pkg;

	// Result status codes
	localparam logic [1:0] ST_ABSENT   = 2'd0;
	localparam logic [1:0] ST_PRESENT  = 2'd1;
	localparam logic [1:0] ST_INSERTED = 2'd2;
	localparam logic [1:0] ST_DROPPED  = 2'd3;

	// Operation codes
	localparam logic OP_SEARCH = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic load;     // capture a new item, restart at the root
		logic rd_root;  // keep the store read port on the root slot
		logic step;     // descend to the chosen child
		logic ins_wr;   // write the key into the current slot
		logic clr_wr;   // clearing pass: empty one slot
		logic out_load; // capture the result into the output register
	} abst_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic used;     // current slot holds a key
		logic eq;       // stored key equals the item key
		logic in_range; // chosen child lies inside the store
		logic insert;   // current item is an insert
		logic clr_last; // clearing pass is at its last slot
	} abst_sts_t;

endpackage

// ----- design/abst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module abst_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/abst_dp.sv -----
// Datapath: item registers, tree index, key compare, clearing counter,
// output register and the slot store. Depends on abst_pkg and abst_ram.
module abst_dp #(
	parameter int CAPACITY  = 63,
	parameter int KEY_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  abst_pkg::abst_cmd_t cmd,
	output abst_pkg::abst_sts_t sts,
	input  logic                operation,
	input  logic [31:0]         key,
	output logic [1:0]          status,
	output logic [5:0]          slot
);

	localparam int KW = (KEY_BYTES >= 4) ? 32 : 8 * KEY_BYTES;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int DP = (CAPACITY > 1) ? CAPACITY : 2;
	localparam int NW = $clog2(2 * CAPACITY + 1);

	logic [KW-1:0] key_q;
	logic          op_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    status_q;
	logic [5:0]    slot_q;

	logic [KW:0]   rdata;
	logic [KW:0]   wdata;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          rd_used;
	logic [KW-1:0] rd_key;
	logic [NW-1:0] idx_ext;
	logic [NW-1:0] next_idx;
	logic [AW+5:0] slot_wide;

	assign rd_used  = rdata[KW];
	assign rd_key   = rdata[KW-1:0];
	assign idx_ext  = NW'(idx_q);
	// go left when the stored key is greater, right otherwise
	assign next_idx = (idx_ext << 1) + ((rd_key > key_q) ? NW'(1) : NW'(2));

	assign sts.used     = rd_used;
	assign sts.eq       = (rd_key == key_q);
	assign sts.in_range = (next_idx < NW'(CAPACITY));
	assign sts.insert   = (op_q == abst_pkg::OP_INSERT);
	assign sts.clr_last = (clr_q == AW'(CAPACITY - 1));

	always_comb begin
		if (cmd.rd_root) begin
			raddr = '0;
		end else if (cmd.step) begin
			raddr = next_idx[AW-1:0];
		end else begin
			raddr = idx_q;
		end
	end

	assign waddr = cmd.clr_wr ? clr_q : idx_q;
	assign wdata = cmd.clr_wr ? '0 : {1'b1, key_q};

	abst_ram #(
		.WIDTH(KW + 1),
		.DEPTH(DP)
	) u_store (
		.clk  (clk),
		.we   (cmd.clr_wr | cmd.ins_wr),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key[KW-1:0];
			op_q  <= operation;
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= next_idx[AW-1:0];
		end
	end

	assign slot_wide = {6'b0, idx_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (!rd_used) begin
				status_q <= sts.insert ? abst_pkg::ST_INSERTED : abst_pkg::ST_ABSENT;
				slot_q   <= sts.insert ? slot_wide[5:0] : 6'd0;
			end else if (sts.eq) begin
				status_q <= abst_pkg::ST_PRESENT;
				slot_q   <= slot_wide[5:0];
			end else begin
				status_q <= sts.insert ? abst_pkg::ST_DROPPED : abst_pkg::ST_ABSENT;
				slot_q   <= 6'd0;
			end
		end
	end

	assign status = status_q;
	assign slot   = slot_q;

endmodule

// ----- design/abst_ctrl.sv -----
// Controller: clearing pass, walk sequencing and output beat valid.
// Depends on abst_pkg.
module abst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  abst_pkg::abst_sts_t sts,
	output abst_pkg::abst_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   finish;
	logic   fire;

	// walk ends on an empty slot, a match, or a child past the store
	assign finish = (state_q == S_WALK) && (!sts.used || sts.eq || !sts.in_range);
	assign fire   = finish && (!out_valid_q || !out_stall);

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign cmd.load     = (state_q == S_IDLE) && in_valid;
	assign cmd.rd_root  = (state_q == S_IDLE);
	assign cmd.step     = (state_q == S_WALK) && !finish;
	assign cmd.ins_wr   = fire && !sts.used && sts.insert;
	assign cmd.clr_wr   = (state_q == S_CLEAR);
	assign cmd.out_load = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/array_bst_insert_search_unit.sv -----
// Top level of the array-backed binary search tree unit.
// Depends on abst_pkg, abst_ctrl, abst_dp (and abst_ram through abst_dp).
//
// The unit keeps a binary search tree in one RAM of CAPACITY slots, slot i
// having children 2i+1 and 2i+2; each slot stores an occupied flag and a key.
// An input beat searches for a key (operation 0) or inserts it (operation 1);
// every input beat yields exactly one output beat with status (absent,
// present, inserted, dropped) and the slot found or written. Keys compare as
// unsigned numbers over their low 8*KEY_BYTES bits. After reset the unit runs
// a clearing pass over all CAPACITY slots, one slot per cycle, with in_stall high.
// An item's walk then descends one tree level at a time (at most 6 levels for
// 63 slots), and the next item is accepted only once the walk ends: the RAM
// has one read port and each level needs one registered read and compare.
// The result sits in an output register, so the next item is accepted while
// an earlier result still waits; a finished walk holds only if that register
// is still full and stalled.
module array_bst_insert_search_unit #(
	parameter int CAPACITY  = 63,
	parameter int KEY_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  slot
);

	abst_pkg::abst_cmd_t cmd;
	abst_pkg::abst_sts_t sts;

	// sequence the clearing pass and the walk
	abst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the item, compare against the store, descend, write, report
	abst_dp #(
		.CAPACITY (CAPACITY),
		.KEY_BYTES(KEY_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.operation(operation),
		.key      (key),
		.status   (status),
		.slot     (slot)
	);

endmodule

// ----- dv/array_bst_insert_search_unit_test.sv -----
// Self-checking testbench for array_bst_insert_search_unit: searches and inserts on the tree,
// checked beat by beat against a tree walk kept inside the bench.
// Depends on abst_pkg and the array_bst_insert_search_unit RTL.
module array_bst_insert_search_unit_test;

	localparam int CAPACITY   = 63;
	localparam int KEY_BYTES  = 4;
	localparam int RANDOM_OPS = 1130;
	localparam int TAIL_ITEMS = 150;     // last stretch of the run runs with no idling
	localparam int HOLD_AT    = 300;     // result count at which the long receiver hold starts
	localparam int HOLD_LEN   = 250;
	localparam int DRAIN_CYC  = 20;
	localparam int CYCLE_MAX  = 400000;
	localparam logic [31:0] KEY_MASK =
		(KEY_BYTES >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * KEY_BYTES)) - 32'd1);

	typedef struct {
		logic        op;
		logic [31:0] key;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [5:0] slot;
	} outcome_t;

	// Block ports; every input starts at a known value.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        operation = abst_pkg::OP_SEARCH;
	logic [31:0] key       = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [5:0]  slot;

	// Bench-side copy of the tree.
	logic [31:0] tree_key  [CAPACITY];
	logic        tree_used [CAPACITY];

	request_t    queued_requests[$];
	outcome_t    pending_outcomes[$];
	logic [31:0] planted_keys[$];

	int total_items  = 0;
	int sent_cnt     = 0;
	int got_cnt      = 0;
	int mismatch_cnt = 0;
	int cycle_cnt    = 0;
	int gap_left     = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	request_t next_req;
	outcome_t outcome_now;

	array_bst_insert_search_unit #(
		.CAPACITY (CAPACITY),
		.KEY_BYTES(KEY_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.key      (key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.slot     (slot)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Walk the tree for one accepted beat, update the copy on insert and
	// queue the outcome the block must report for it.
	function automatic void walk_tree(input logic op, input logic [31:0] raw_key);
		logic [31:0] k;
		int unsigned idx;
		bit          done;
		outcome_t    res;
		k          = raw_key & KEY_MASK;
		idx        = 0;
		done       = 1'b0;
		res.status = (op == abst_pkg::OP_INSERT) ? abst_pkg::ST_DROPPED : abst_pkg::ST_ABSENT;
		res.slot   = 6'd0;
		while (!done && idx < CAPACITY) begin
			if (!tree_used[idx]) begin
				// first empty slot on the path ends the walk
				if (op == abst_pkg::OP_INSERT) begin
					tree_key[idx]  = k;
					tree_used[idx] = 1'b1;
					res.status     = abst_pkg::ST_INSERTED;
					res.slot       = idx[5:0];
				end else begin
					res.status = abst_pkg::ST_ABSENT;
				end
				done = 1'b1;
			end else if (tree_key[idx] == k) begin
				// a duplicate insert reports present and writes nothing
				res.status = abst_pkg::ST_PRESENT;
				res.slot   = idx[5:0];
				done       = 1'b1;
			end else if (tree_key[idx] > k) begin
				idx = 2 * idx + 1;
			end else begin
				idx = 2 * idx + 2;
			end
		end
		// falling off the bottom leaves absent or dropped with slot 0
		pending_outcomes.push_back(res);
	endfunction

	// Random idle bursts stay on for two hundred of every three hundred beats
	// and stop for good over the last stretch.
	function automatic bit idling_on(input int n);
		return (n < total_items - TAIL_ITEMS) && ((n / 100) % 3 != 2);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("MISMATCH at result %0d: %s got %0h expected %0h", got_cnt, what, seen, wanted);
		mismatch_cnt++;
	endtask

	task automatic queue_request(input logic op, input logic [31:0] k);
		request_t r;
		r.op  = op;
		r.key = k;
		queued_requests.push_back(r);
	endtask

	// Input driver: predict on each accepted beat, then either hold the
	// stalled beat, sit out an idle burst, or present the next request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= abst_pkg::OP_SEARCH;
			key       <= 32'd0;
			gap_left  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				walk_tree(operation, key);
				sent_cnt++;
			end
			// a stalled beat stays on the bus untouched
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (queued_requests.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idling_on(sent_cnt) && $urandom_range(0, 11) == 0) begin
					gap_left = $urandom_range(1, 19) - 1;
					in_valid <= 1'b0;
				end else begin
					next_req = queued_requests.pop_front();
					in_valid  <= 1'b1;
					operation <= next_req.op;
					key       <= next_req.key;
				end
			end
		end
	end

	// Result monitor and receiver: check each accepted beat against the
	// oldest outcome, then pick the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_cnt++;
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result with nothing pending, status", 32'(status),
						32'd0);
				end else begin
					outcome_now = pending_outcomes.pop_front();
					if (status !== outcome_now.status)
						report_mismatch("status", 32'(status), 32'(outcome_now.status));
					if (slot !== outcome_now.slot)
						report_mismatch("slot", 32'(slot), 32'(outcome_now.slot));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && got_cnt >= HOLD_AT) begin
				// long hold: the output register fills and the walk backs up
				// into in_stall while the driver keeps offering beats
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_stall <= 1'b1;
			end else if (idling_on(got_cnt) && $urandom_range(0, 11) == 0) begin
				hold_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_MAX) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          pick;
		logic [31:0] k;
		for (int s = 0; s < CAPACITY; s++) begin
			tree_key[s]  = 32'd0;
			tree_used[s] = 1'b0;
		end

		// Directed: empty tree, root, extremes, duplicates, a path that
		// runs off the bottom for both insert and search.
		queue_request(abst_pkg::OP_SEARCH, 32'h0000_0000);   // empty tree
		queue_request(abst_pkg::OP_SEARCH, 32'hFFFF_FFFF);
		queue_request(abst_pkg::OP_INSERT, 32'h8000_0000);   // root
		queue_request(abst_pkg::OP_INSERT, 32'h8000_0000);   // duplicate insert
		queue_request(abst_pkg::OP_SEARCH, 32'h8000_0000);
		queue_request(abst_pkg::OP_INSERT, 32'h0000_0000);   // smallest key, left of root
		queue_request(abst_pkg::OP_INSERT, 32'hFFFF_FFFF);   // largest key, right of root
		queue_request(abst_pkg::OP_SEARCH, 32'h0000_0000);
		queue_request(abst_pkg::OP_SEARCH, 32'hFFFF_FFFF);
		queue_request(abst_pkg::OP_SEARCH, 32'h7FFF_FFFF);   // absent at an empty child
		queue_request(abst_pkg::OP_INSERT, 32'h4000_0000);   // descend right of key 0 ...
		queue_request(abst_pkg::OP_INSERT, 32'h6000_0000);
		queue_request(abst_pkg::OP_INSERT, 32'h7000_0000);
		queue_request(abst_pkg::OP_INSERT, 32'h7800_0000);   // ... down to the last level
		queue_request(abst_pkg::OP_INSERT, 32'h7C00_0000);   // next child past capacity: dropped
		queue_request(abst_pkg::OP_SEARCH, 32'h7C00_0000);   // search past capacity: absent
		queue_request(abst_pkg::OP_SEARCH, 32'h7800_0000);   // present at the deepest level
		queue_request(abst_pkg::OP_INSERT, 32'h2000_0000);
		queue_request(abst_pkg::OP_INSERT, 32'h9000_0000);   // left of the largest key
		queue_request(abst_pkg::OP_SEARCH, 32'hAAAA_AAAA);
		queue_request(abst_pkg::OP_SEARCH, 32'h5555_5555);
		queue_request(abst_pkg::OP_INSERT, 32'hFFFF_FFFF);   // duplicate of an extreme
		foreach (queued_requests[i])
			if (queued_requests[i].op == abst_pkg::OP_INSERT)
				planted_keys.push_back(queued_requests[i].key);

		// Random: fresh keys, neighbors of stored keys to fill in the lower
		// levels, repeat lookups and the extremes.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				k = $urandom;
				queue_request(abst_pkg::OP_INSERT, k);
				planted_keys.push_back(k);
			end else if (pick < 50) begin
				k = planted_keys[$urandom_range(0, planted_keys.size() - 1)]
					+ $urandom_range(0, 8) - 4;
				queue_request(abst_pkg::OP_INSERT, k);
				planted_keys.push_back(k);
			end else if (pick < 75) begin
				queue_request(abst_pkg::OP_SEARCH,
					planted_keys[$urandom_range(0, planted_keys.size() - 1)]);
			end else if (pick < 90) begin
				queue_request(abst_pkg::OP_SEARCH, $urandom);
			end else begin
				case ($urandom_range(0, 3))
					0: k = 32'h0000_0000;
					1: k = 32'hFFFF_FFFF;
					2: k = 32'h8000_0000;
					default: k = 32'h7FFF_FFFF;
				endcase
				queue_request($urandom_range(0, 1) ? abst_pkg::OP_INSERT : abst_pkg::OP_SEARCH,
					k);
			end
		end
		total_items = queued_requests.size();

		// Hold reset, then release it; the clearing pass that follows keeps
		// in_stall high, so the driver simply waits on the handshake.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_cnt < total_items || pending_outcomes.size() != 0)
			@(posedge clk);
		// drain: any late extra beat shows up as a result with nothing pending
		repeat (DRAIN_CYC) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
